FILE: hdl/bcev_pkg.sv
package bcev_pkg;

  // Storage size of the control-point memory.
  localparam int unsigned MAX_POINTS = 8;
  localparam int unsigned PTR_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = PTR_W + 1;

  // Fixed-point formats.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DIVD_W    = 48;
  localparam int unsigned DIVS_W    = 32;
  localparam logic [16:0] ONE_Q16   = 17'h10000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_START = 2'd0,
    CFG_END   = 2'd1,
    CFG_COUNT = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SAT     = 3'd1,
    ST_ORDER   = 3'd2,
    ST_BAD_INT = 3'd3,
    ST_CLAMPED = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_POW_U,
    S_POW_V,
    S_WEIGHT,
    S_BINOM,
    S_DIFF,
    S_TERM,
    S_SCALE,
    S_SAT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               operation;
    logic [2:0]         point_index;
    logic signed [31:0] point_value;
    logic [31:0]        time_value;
    logic [1:0]         derivative_order;
  } in_t;

  typedef struct packed {
    logic signed [47:0] curve_value;
    logic [2:0]         status;
  } out_t;

  // Binomial coefficients, row-major by degree, built at elaboration.
  typedef logic [5:0] binom_tab_t [64];

  function automatic binom_tab_t gen_binom();
    binom_tab_t tab;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        if (c == 0) begin
          tab[r*8+c] = 6'd1;
        end else if (c > r) begin
          tab[r*8+c] = 6'd0;
        end else begin
          tab[r*8+c] = tab[(r-1)*8+c-1] + tab[(r-1)*8+c];
        end
      end
    end
    return tab;
  endfunction

  localparam binom_tab_t BINOM_TAB = gen_binom();

  // Falling factorial n(n-1)..(n-k+1) for n up to 7 and k up to 3.
  function automatic logic [7:0] falling(input logic [2:0] n, input logic [1:0] k);
    logic [7:0]  f;
    logic [10:0] p;
    f = 8'd1;
    for (int i = 0; i < 3; i++) begin
      if (i < int'(k)) begin
        p = f * (n - 3'(i));
        f = p[7:0];
      end
    end
    return f;
  endfunction

endpackage

FILE: hdl/bcev_div.sv
module bcev_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bcev_pkg::DIVD_W-1:0]  dividend_i,
  input  logic [bcev_pkg::DIVS_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [bcev_pkg::DIVD_W-1:0]  quotient_o
);

  localparam int unsigned STEP_W = $clog2(bcev_pkg::DIVD_W + 1);

  logic [bcev_pkg::DIVD_W-1:0] quo_q;
  logic [bcev_pkg::DIVS_W-1:0] dvs_q;
  logic [bcev_pkg::DIVS_W:0]   rem_q;
  logic [STEP_W-1:0]           step_q;
  logic                        busy_q;
  logic                        done_q;
  logic [bcev_pkg::DIVS_W:0]   rem_sh;
  logic [bcev_pkg::DIVS_W:0]   rem_sub;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_sh  = {rem_q[bcev_pkg::DIVS_W-1:0], quo_q[bcev_pkg::DIVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(bcev_pkg::DIVD_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath needs no reset.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!rem_sub[bcev_pkg::DIVS_W]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[bcev_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[bcev_pkg::DIVD_W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hdl/bezier_curve_evaluator_unit.sv
// Bezier curve evaluator. A write transaction stores one control point. An
// evaluate transaction normalizes the time with a bit-serial divider, then
// walks the Bernstein terms i = 0..m (m = degree - order) on one shared
// multiplier. Bad interval and order above degree answer without the divider.
// The input is stalled while an evaluation runs; one finished result may wait
// in the output register while the next transaction is taken.
module bezier_curve_evaluator_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bcev_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bcev_pkg::out_t   out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  bcev_pkg::state_e state_q, state_d;

  logic [31:0] start_q, end_q;
  logic [3:0]  count_q;
  logic signed [31:0] pos_q [bcev_pkg::MAX_POINTS];

  logic [16:0] u_q, v_q, p_q, q_q;
  logic [2:0]  i_q, m_q, cnt_q;
  logic [1:0]  j_q, ord_q;
  logic [21:0] w_q;
  logic signed [35:0] d_q;
  logic signed [41:0] t_q;
  logic signed [55:0] acc_q;
  logic [7:0]  ff_q;
  logic        clamp_q;
  logic signed [47:0] res_val_q;
  logic [2:0]  res_st_q;
  logic        out_valid_q;
  bcev_pkg::out_t out_q;

  logic        in_acc, eval_acc, write_acc;
  logic [3:0]  count_eff;
  logic [2:0]  n_w;
  logic        bad_int, bad_ord;
  logic [31:0] t_clamp;
  logic        t_lo, t_hi;
  logic        div_start, div_done;
  logic [bcev_pkg::DIVD_W-1:0] div_quo;
  logic signed [24:0] mul_a;
  logic signed [47:0] mul_b;
  logic signed [72:0] prod;
  logic [3:0]  rd_sum;
  logic signed [35:0] pt_ext, pt_mul;
  logic [5:0]  diff_c;
  logic        diff_neg;
  logic        out_free;

  assign cfg_ready_o = 1'b1;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign eval_acc  = in_acc && in_data_i.operation;
  assign write_acc = in_acc && !in_data_i.operation;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Effective degree and early checks.
  always_comb begin
    count_eff = count_q;
    if (count_q < 4'd2) begin
      count_eff = 4'd2;
    end else if (count_q > 4'(bcev_pkg::MAX_POINTS)) begin
      count_eff = 4'(bcev_pkg::MAX_POINTS);
    end
    n_w     = 3'(count_eff - 4'd1);
    bad_int = end_q <= start_q;
    bad_ord = {1'b0, in_data_i.derivative_order} > n_w;
    t_lo    = in_data_i.time_value < start_q;
    t_hi    = in_data_i.time_value > end_q;
    t_clamp = t_lo ? start_q : (t_hi ? end_q : in_data_i.time_value);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bcev_pkg::S_IDLE: begin
        if (eval_acc) begin
          state_d = (bad_int || bad_ord) ? bcev_pkg::S_DONE : bcev_pkg::S_DIV;
        end
      end
      bcev_pkg::S_DIV: begin
        if (div_done) begin
          state_d = bcev_pkg::S_POW_U;
        end
      end
      bcev_pkg::S_POW_U: begin
        if (cnt_q == 3'd0) begin
          state_d = bcev_pkg::S_POW_V;
        end
      end
      bcev_pkg::S_POW_V: begin
        if (cnt_q == 3'd0) begin
          state_d = bcev_pkg::S_WEIGHT;
        end
      end
      bcev_pkg::S_WEIGHT: state_d = bcev_pkg::S_BINOM;
      bcev_pkg::S_BINOM:  state_d = bcev_pkg::S_DIFF;
      bcev_pkg::S_DIFF: begin
        if (j_q == ord_q) begin
          state_d = bcev_pkg::S_TERM;
        end
      end
      bcev_pkg::S_TERM:   state_d = bcev_pkg::S_SCALE;
      bcev_pkg::S_SCALE: begin
        state_d = (i_q == m_q) ? bcev_pkg::S_SAT : bcev_pkg::S_POW_U;
      end
      bcev_pkg::S_SAT:    state_d = bcev_pkg::S_DONE;
      bcev_pkg::S_DONE: begin
        if (out_free) begin
          state_d = bcev_pkg::S_IDLE;
        end
      end
      default:            state_d = bcev_pkg::S_IDLE;
    endcase
  end

  // Control outputs and shared multiplier operands.
  always_comb begin
    in_stall_o = state_q != bcev_pkg::S_IDLE;
    div_start  = eval_acc && !bad_int && !bad_ord;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      bcev_pkg::S_POW_U: begin
        mul_a = {8'd0, u_q};
        mul_b = {31'd0, p_q};
      end
      bcev_pkg::S_POW_V: begin
        mul_a = {8'd0, v_q};
        mul_b = {31'd0, q_q};
      end
      bcev_pkg::S_WEIGHT: begin
        mul_a = {8'd0, p_q};
        mul_b = {31'd0, q_q};
      end
      bcev_pkg::S_BINOM: begin
        mul_a = {19'd0, bcev_pkg::BINOM_TAB[{m_q, i_q}]};
        mul_b = {26'd0, w_q};
      end
      bcev_pkg::S_TERM: begin
        mul_a = {3'd0, w_q};
        mul_b = {{12{d_q[35]}}, d_q};
      end
      bcev_pkg::S_SCALE: begin
        mul_a = {17'd0, ff_q};
        mul_b = {{6{t_q[41]}}, t_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Forward difference step: add or subtract C(order, j) times one point.
  always_comb begin
    rd_sum   = {1'b0, i_q} + {2'b0, j_q};
    pt_ext   = 36'(pos_q[rd_sum[bcev_pkg::PTR_W-1:0]]);
    diff_c   = bcev_pkg::BINOM_TAB[{3'(ord_q), 3'(j_q)}];
    diff_neg = (ord_q[0] ^ j_q[0]);
    if (diff_c == 6'd3) begin
      pt_mul = pt_ext + (pt_ext <<< 1);
    end else if (diff_c == 6'd2) begin
      pt_mul = pt_ext <<< 1;
    end else begin
      pt_mul = pt_ext;
    end
  end

  bcev_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({t_clamp - start_q, 16'd0}),
    .divisor_i  (end_q - start_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcev_pkg::S_IDLE;
      start_q     <= 32'd0;
      end_q       <= 32'd65536;
      count_q     <= 4'd4;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (bcev_pkg::cfg_idx_e'(cfg_index_i))
          bcev_pkg::CFG_START: start_q <= cfg_data_i;
          bcev_pkg::CFG_END:   end_q   <= cfg_data_i;
          bcev_pkg::CFG_COUNT: count_q <= cfg_data_i[3:0];
          default:             ;
        endcase
      end
      if (state_q == bcev_pkg::S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Control-point store.
  always_ff @(posedge clk_i) begin
    if (write_acc && ({1'b0, in_data_i.point_index} < 4'(bcev_pkg::MAX_POINTS))) begin
      pos_q[in_data_i.point_index[bcev_pkg::PTR_W-1:0]] <= in_data_i.point_value;
    end
  end

  // Evaluation datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      bcev_pkg::S_IDLE: begin
        ord_q   <= in_data_i.derivative_order;
        m_q     <= n_w - {1'b0, in_data_i.derivative_order};
        ff_q    <= bcev_pkg::falling(n_w, in_data_i.derivative_order);
        clamp_q <= t_lo || t_hi;
        acc_q   <= '0;
        i_q     <= '0;
        res_val_q <= '0;
        res_st_q  <= bad_int ? 3'(bcev_pkg::ST_BAD_INT) : 3'(bcev_pkg::ST_ORDER);
      end
      bcev_pkg::S_DIV: begin
        u_q   <= div_quo[16:0];
        v_q   <= bcev_pkg::ONE_Q16 - div_quo[16:0];
        p_q   <= bcev_pkg::ONE_Q16;
        q_q   <= bcev_pkg::ONE_Q16;
        cnt_q <= '0;
      end
      bcev_pkg::S_POW_U: begin
        if (cnt_q == 3'd0) begin
          cnt_q <= m_q - i_q;
        end else begin
          p_q   <= prod[32:16];
          cnt_q <= cnt_q - 3'd1;
        end
      end
      bcev_pkg::S_POW_V: begin
        if (cnt_q != 3'd0) begin
          q_q   <= prod[32:16];
          cnt_q <= cnt_q - 3'd1;
        end
      end
      bcev_pkg::S_WEIGHT: begin
        w_q <= {5'd0, prod[32:16]};
      end
      bcev_pkg::S_BINOM: begin
        w_q <= prod[21:0];
        d_q <= '0;
        j_q <= '0;
      end
      bcev_pkg::S_DIFF: begin
        d_q <= diff_neg ? d_q - pt_mul : d_q + pt_mul;
        j_q <= j_q + 2'd1;
      end
      bcev_pkg::S_TERM: begin
        t_q <= prod[57:16];
      end
      bcev_pkg::S_SCALE: begin
        acc_q <= acc_q + prod[55:0];
        i_q   <= i_q + 3'd1;
        p_q   <= bcev_pkg::ONE_Q16;
        q_q   <= bcev_pkg::ONE_Q16;
        cnt_q <= i_q + 3'd1;
      end
      bcev_pkg::S_SAT: begin
        if (acc_q > 56'sh0000_7FFF_FFFF_FFFF) begin
          res_val_q <= 48'sh7FFF_FFFF_FFFF;
          res_st_q  <= 3'(bcev_pkg::ST_SAT);
        end else if (acc_q < -56'sh0000_8000_0000_0000) begin
          res_val_q <= -48'sh8000_0000_0000;
          res_st_q  <= 3'(bcev_pkg::ST_SAT);
        end else begin
          res_val_q <= acc_q[47:0];
          res_st_q  <= clamp_q ? 3'(bcev_pkg::ST_CLAMPED) : 3'(bcev_pkg::ST_OK);
        end
      end
      bcev_pkg::S_DONE: begin
        if (out_free) begin
          out_q.curve_value <= res_val_q;
          out_q.status      <= res_st_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
